@@ rtl/i2cms_pkg.sv @@
// Shared types, command codes and phase helpers for the I2C master bit sequencer.
package i2cms_pkg;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_RECV  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_RACK  = 3'd6
  } cmd_e_t;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned PHASE_W = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IN_DW   = 16;
  localparam int unsigned OUT_DW  = 16;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] tx_data;
    logic              ack_level;
    logic              sda_in;
  } item_t;

  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_seen;
    logic              rejected;
  } res_t;

  // Number of bus phases each command takes.
  function automatic logic [PHASE_W-1:0] phase_total(cmd_e_t cmd);
    logic [PHASE_W-1:0] n;
    unique case (cmd)
      CMD_START: n = 5'd4;
      CMD_STOP:  n = 5'd3;
      CMD_SEND:  n = 5'd24;
      CMD_RECV:  n = 5'd17;
      CMD_SACK:  n = 5'd3;
      CMD_RACK:  n = 5'd3;
      default:   n = 5'd0;
    endcase
    return n;
  endfunction

  // Position inside a three-phase bit slot, by conditional subtraction.
  function automatic logic [1:0] slot_of(logic [PHASE_W-1:0] p);
    logic [PHASE_W-1:0] r;
    r = p;
    if (r >= 5'd24) r = r - 5'd24;
    if (r >= 5'd12) r = r - 5'd12;
    if (r >= 5'd6)  r = r - 5'd6;
    if (r >= 5'd3)  r = r - 5'd3;
    return r[1:0];
  endfunction

endpackage

@@ rtl/i2cms_seq.sv @@
// Phase sequencer: bus state registers and the per-phase update logic.
module i2cms_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  i2cms_pkg::item_t item,
  output i2cms_pkg::res_t  res
);
  import i2cms_pkg::*;

  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  cmd_e_t             cmd_r, cmd_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [BYTE_W-1:0]  rx_r, rx_nxt;
  logic               ack_r, ack_nxt;

  logic               is_cmd;
  logic               launch;
  cmd_e_t             cmd_a;
  logic [PHASE_W-1:0] p_a;
  logic [PHASE_W-1:0] p_inc;
  logic [1:0]         slot;
  logic               done;

  assign is_cmd = (item.kind >= CMD_START) && (item.kind <= CMD_RACK);
  assign launch = is_cmd && (cmd_r == CMD_NONE);
  assign cmd_a  = launch ? cmd_e_t'(item.kind) : cmd_r;
  assign p_a    = launch ? '0 : phase_r;
  assign p_inc  = p_a + 5'd1;
  assign slot   = slot_of(p_a);

  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    cmd_nxt   = cmd_a;
    phase_nxt = p_a;
    done      = 1'b0;
    if (launch) begin
      if (cmd_a == CMD_SEND)      shift_nxt = item.tx_data;
      else if (cmd_a == CMD_SACK) shift_nxt = {{(BYTE_W-1){1'b0}}, item.ack_level};
      else                        shift_nxt = '0;
    end else begin
      shift_nxt = shift_r;
    end

    unique case (cmd_a)
      CMD_START: begin
        priority if (p_a == 5'd0) sda_nxt = 1'b1;
        else if (p_a == 5'd1)     scl_nxt = 1'b1;
        else if (p_a == 5'd2)     sda_nxt = 1'b0;
        else                      scl_nxt = 1'b0;
      end
      CMD_STOP: begin
        priority if (p_a == 5'd0) sda_nxt = 1'b0;
        else if (p_a == 5'd1)     scl_nxt = 1'b1;
        else                      sda_nxt = 1'b1;
      end
      CMD_SEND: begin
        priority if (slot == 2'd0) sda_nxt = shift_nxt[BYTE_W-1];
        else if (slot == 2'd1)     scl_nxt = 1'b1;
        else begin
          scl_nxt   = 1'b0;
          shift_nxt = {shift_nxt[BYTE_W-2:0], 1'b0};
        end
      end
      CMD_RECV: begin
        // Odd phases raise SCL; even phases after the first sample and drop it.
        priority if (p_a == 5'd0) sda_nxt = 1'b1;
        else if (p_a[0])          scl_nxt = 1'b1;
        else begin
          shift_nxt = {shift_nxt[BYTE_W-2:0], item.sda_in};
          scl_nxt   = 1'b0;
        end
      end
      CMD_SACK: begin
        priority if (p_a == 5'd0) sda_nxt = shift_nxt[0];
        else if (p_a == 5'd1)     scl_nxt = 1'b1;
        else                      scl_nxt = 1'b0;
      end
      CMD_RACK: begin
        priority if (p_a == 5'd0) sda_nxt = 1'b1;
        else if (p_a == 5'd1)     scl_nxt = 1'b1;
        else begin
          ack_nxt = item.sda_in;
          scl_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    if (cmd_a != CMD_NONE) begin
      if (p_inc >= phase_total(cmd_a)) begin
        if (cmd_a == CMD_RECV) rx_nxt = shift_nxt;
        cmd_nxt   = CMD_NONE;
        phase_nxt = '0;
        done      = 1'b1;
      end else begin
        phase_nxt = p_inc;
      end
    end
  end

  assign res.scl_out  = scl_nxt;
  assign res.sda_out  = sda_nxt;
  assign res.busy_res = (cmd_nxt != CMD_NONE);
  assign res.done_res = done;
  assign res.rx_byte  = rx_nxt;
  assign res.ack_seen = ack_nxt;
  assign res.rejected = is_cmd && !launch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      cmd_r   <= CMD_NONE;
      phase_r <= '0;
      shift_r <= '0;
      rx_r    <= '0;
      ack_r   <= 1'b1;
    end else if (step) begin
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      cmd_r   <= cmd_nxt;
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      rx_r    <= rx_nxt;
      ack_r   <= ack_nxt;
    end
  end

  a_idle_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r == CMD_NONE) |-> (phase_r == '0))
    else $error("phase count nonzero while idle");

  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r != CMD_NONE) |-> (phase_r < phase_total(cmd_r)))
    else $error("phase count beyond command length");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.done_res) |=> (cmd_r == CMD_NONE))
    else $error("command still active after its last phase");

endmodule

@@ rtl/i2c_master_bit_sequencer_top.sv @@
// A request passes through the input register and then the result register before its result is shown.
// Throughput: one request per cycle while out_tready is high; in_tready follows the result register's space.
// The result register holds while a result is pending and out_tready is low; the input register takes at most one
// more request, then in_tready drops until the result is taken.
// Reset (rst_n low, synchronous): both lines released, no command, received byte 0, ack 1.
// Each request advances the running command by one bus phase.
module i2c_master_bit_sequencer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // tdata: tx_data[7:0], ack_level[8], sda_in[9], zero[15:10]
  input  logic [i2cms_pkg::IN_DW-1:0]  in_tdata,
  // tuser: kind[2:0]
  input  logic [i2cms_pkg::KIND_W-1:0] in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // tdata: scl_out[0], sda_out[1], busy_res[2], rx_byte[10:3], ack_seen[11],
  //        rejected[12], zero[15:13]
  output logic [i2cms_pkg::OUT_DW-1:0] out_tdata,
  // tlast: done_res, last phase of a command
  output logic                         out_tlast
);
  import i2cms_pkg::*;

  logic  in_valid_r;
  item_t item_r;
  logic  out_valid_r;
  res_t  res_r;
  res_t  res;
  logic  advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  i2cms_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers: load on transfer only.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.kind      <= in_tuser;
      item_r.tx_data   <= in_tdata[7:0];
      item_r.ack_level <= in_tdata[8];
      item_r.sda_in    <= in_tdata[9];
    end
    if (advance) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.done_res;
  assign out_tdata  = {3'b000, res_r.rejected, res_r.ack_seen, res_r.rx_byte,
                       res_r.busy_res, res_r.sda_out, res_r.scl_out};

endmodule
